FILE: rtl/core/lpa_pkg.sv
// Shared types, codes and sizes of the linked pool allocator.
package lpa_pkg;

  localparam int POOL_ENTRIES = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int LIST_LIMIT   = (MAX_RESULTS < POOL_ENTRIES) ? MAX_RESULTS : POOL_ENTRIES;

  localparam int INDEX_W = 5;
  localparam int VALUE_W = 32;
  localparam int ADDR_W  = $clog2(POOL_ENTRIES);
  localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W   = (LIST_LIMIT > 1) ? $clog2(LIST_LIMIT) : 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LINK_W-1:0] link_t;

  // Any link value at or above the pool size means no link.
  localparam link_t LINK_NULL = LINK_W'(POOL_ENTRIES);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_LIST  = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_POOL_EMPTY = 2'd1;
  localparam logic [1:0] STAT_NOT_ACTIVE = 2'd2;
  localparam logic [1:0] STAT_LIST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_F_IDX,
    ST_F_WALK,
    ST_F_DONE,
    ST_L_WALK
  } state_t;

  function automatic logic link_valid_f(input link_t l);
    return l < LINK_NULL;
  endfunction

  function automatic link_t reset_link(input addr_t a);
    link_t r;
    if (LINK_W'(a) == LINK_W'(POOL_ENTRIES - 1)) begin
      r = LINK_NULL;
    end else begin
      r = LINK_W'(a) + LINK_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/linked_pool_allocator_unit.sv
// Linked pool allocator: free and active lists kept in a link memory and a value memory.
// Allocate: result registered from ST_ALLOC; pool empty, inactive free: in the cycle after accept.
// Free of an active entry: the head finishes in ST_F_IDX; a deeper entry comes later, by its depth,
// through ST_F_WALK and ST_F_DONE, since the predecessor search follows one link memory read per cycle.
// List: beats are registered from ST_L_WALK, one beat per cycle, up to 32 beats.
// busy stays high until the last beat is issued; results cannot be stalled.
// Synchronous reset rebuilds both lists through per-entry link written bits.
module linked_pool_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [lpa_pkg::INDEX_W-1:0] entry_index,
  input  logic [lpa_pkg::VALUE_W-1:0] value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [lpa_pkg::INDEX_W-1:0] entry_index_res,
  output logic [lpa_pkg::VALUE_W-1:0] value_res,
  output logic                       last
);
  import lpa_pkg::*;

  state_t state, state_next;

  link_t active_head, active_head_next;
  link_t free_head, free_head_next;
  logic [POOL_ENTRIES-1:0] active_flag;
  logic [POOL_ENTRIES-1:0] link_written;

  // Item registers.
  addr_t              idx_q;
  logic [VALUE_W-1:0] val_q;
  logic               head_hit;
  addr_t              p, p_next;
  link_t              idx_link;
  logic [CNT_W-1:0]   cnt, cnt_next;

  // Memories.
  link_t              link_mem [POOL_ENTRIES];
  logic [VALUE_W-1:0] value_mem [POOL_ENTRIES];
  link_t              link_raw;
  logic               rd_written;
  addr_t              raddr, raddr_q;
  logic [VALUE_W-1:0] value_rd;
  link_t              link_rd;
  logic               link_we, value_we;
  addr_t              link_waddr;
  link_t              link_wdata;

  // Emitted beat.
  logic               emit;
  logic [1:0]         emit_status;
  addr_t              emit_idx;
  logic [VALUE_W-1:0] emit_value;
  logic               emit_last;
  logic               flag_set, flag_clr;
  addr_t              flag_addr;

  logic  accept;
  logic  idx_in_pool;
  addr_t idx_addr;
  logic  list_end;

  assign accept      = start && !busy;
  assign busy        = (state != ST_IDLE);
  assign idx_in_pool = 32'(entry_index) < 32'(POOL_ENTRIES);
  assign idx_addr    = ADDR_W'(entry_index);
  assign link_rd     = rd_written ? link_raw : reset_link(raddr_q);
  assign list_end    = !link_valid_f(link_rd) || (cnt == CNT_W'(LIST_LIMIT - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_ALLOC: if (link_valid_f(free_head)) state_next = ST_ALLOC;
            OP_FREE:  if (idx_in_pool && active_flag[idx_addr]) state_next = ST_F_IDX;
            OP_LIST:  if (link_valid_f(active_head)) state_next = ST_L_WALK;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC:  state_next = ST_IDLE;
      ST_F_IDX:  state_next = head_hit ? ST_IDLE : ST_F_WALK;
      ST_F_WALK: begin
        if (!link_valid_f(link_rd) || link_rd == LINK_W'(idx_q)) state_next = ST_F_DONE;
      end
      ST_F_DONE: state_next = ST_IDLE;
      ST_L_WALK: if (list_end) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory controls, list heads and result beats.
  always_comb begin
    active_head_next = active_head;
    free_head_next   = free_head;
    p_next           = p;
    cnt_next         = cnt;
    raddr            = p;
    link_we          = 1'b0;
    link_waddr       = p;
    link_wdata       = LINK_NULL;
    value_we         = 1'b0;
    emit             = 1'b0;
    emit_status      = STAT_OK;
    emit_idx         = '0;
    emit_value       = '0;
    emit_last        = 1'b1;
    flag_set         = 1'b0;
    flag_clr         = 1'b0;
    flag_addr        = idx_q;
    case (state)
      ST_IDLE: begin
        case (opcode)
          OP_ALLOC: raddr = ADDR_W'(free_head);
          OP_FREE:  raddr = idx_addr;
          default:  raddr = ADDR_W'(active_head);
        endcase
        p_next   = ADDR_W'(active_head);
        cnt_next = '0;
        if (accept) begin
          case (opcode)
            OP_ALLOC: begin
              if (!link_valid_f(free_head)) begin
                emit        = 1'b1;
                emit_status = STAT_POOL_EMPTY;
              end
            end
            OP_FREE: begin
              if (!(idx_in_pool && active_flag[idx_addr])) begin
                emit        = 1'b1;
                emit_status = STAT_NOT_ACTIVE;
                emit_idx    = idx_addr;
              end
            end
            OP_LIST: begin
              if (!link_valid_f(active_head)) begin
                emit        = 1'b1;
                emit_status = STAT_LIST_EMPTY;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ST_ALLOC: begin
        link_we          = 1'b1;
        link_waddr       = ADDR_W'(free_head);
        link_wdata       = active_head;
        value_we         = 1'b1;
        active_head_next = free_head;
        free_head_next   = link_rd;
        flag_set         = 1'b1;
        flag_addr        = ADDR_W'(free_head);
        emit             = 1'b1;
        emit_idx         = ADDR_W'(free_head);
      end
      ST_F_IDX: begin
        raddr = ADDR_W'(active_head);
        if (head_hit) begin
          active_head_next = link_rd;
          link_we          = 1'b1;
          link_waddr       = idx_q;
          link_wdata       = free_head;
          free_head_next   = LINK_W'(idx_q);
          flag_clr         = 1'b1;
          emit             = 1'b1;
          emit_idx         = idx_q;
        end
      end
      ST_F_WALK: begin
        // p holds the entry whose link is on the read port now.
        raddr  = ADDR_W'(link_rd);
        p_next = ADDR_W'(link_rd);
        if (link_rd == LINK_W'(idx_q)) begin
          link_we    = 1'b1;
          link_waddr = p;
          link_wdata = idx_link;
        end
      end
      ST_F_DONE: begin
        link_we        = 1'b1;
        link_waddr     = idx_q;
        link_wdata     = free_head;
        free_head_next = LINK_W'(idx_q);
        flag_clr       = 1'b1;
        emit           = 1'b1;
        emit_idx       = idx_q;
      end
      ST_L_WALK: begin
        raddr      = ADDR_W'(link_rd);
        p_next     = ADDR_W'(link_rd);
        cnt_next   = cnt + CNT_W'(1);
        emit       = 1'b1;
        emit_idx   = p;
        emit_value = value_rd;
        emit_last  = list_end;
      end
      default: emit = 1'b0;
    endcase
  end

  // Link memory with a written bit per entry; unwritten entries read their reset link.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_raw   <= link_mem[raddr];
    rd_written <= link_written[raddr] || (link_we && link_waddr == raddr);
    raddr_q    <= raddr;
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[ADDR_W'(free_head)] <= val_q;
    end
    value_rd <= value_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_head  <= LINK_NULL;
      free_head    <= '0;
      active_flag  <= '0;
      link_written <= '0;
      done         <= 1'b0;
    end else begin
      state       <= state_next;
      active_head <= active_head_next;
      free_head   <= free_head_next;
      done        <= emit;
      if (link_we) begin
        link_written[link_waddr] <= 1'b1;
      end
      if (flag_set) begin
        active_flag[flag_addr] <= 1'b1;
      end
      if (flag_clr) begin
        active_flag[flag_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p   <= p_next;
    cnt <= cnt_next;
    if (accept) begin
      idx_q    <= idx_addr;
      val_q    <= value;
      head_hit <= (LINK_W'(idx_addr) == active_head);
    end
    if (state == ST_F_IDX) begin
      idx_link <= link_rd;
    end
    status          <= emit_status;
    entry_index_res <= INDEX_W'(emit_idx);
    value_res       <= emit_value;
    last            <= emit_last;
  end

  // A list burst runs without gaps until its last beat.
  a_burst: assert property (@(posedge clk) disable iff (rst) done && !last |=> done)
    else $error("list burst broken before its last beat");

  // The two list heads never name the same entry.
  a_heads: assert property (@(posedge clk) disable iff (rst)
    link_valid_f(active_head) |-> active_head != free_head)
    else $error("free and active heads overlap");

  // An allocate with no free entry reports pool empty on the next cycle.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == OP_ALLOC && !link_valid_f(free_head)
    |=> done && status == STAT_POOL_EMPTY && last)
    else $error("pool empty not reported");

  // The link memory is only written while an item is in progress.
  a_we: assert property (@(posedge clk) disable iff (rst) link_we |-> busy)
    else $error("link write while idle");

endmodule
